// ===== sv/kmst_pkg.sv =====
package kmst_pkg;

  // Table geometry. The home slot keeps only the low bits of the hash
  // product, so the depth is a power of two.
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned SUM_W  = 44;

  // Multiplicative hash constant; it also stands in for a key of zero.
  localparam logic [KEY_W-1:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;

  // Configuration port.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REG_W  = ADDR_W - 2;
  localparam logic [REG_W-1:0] REG_LOAD_LIMIT = '0;
  localparam logic [CNT_W-1:0] LOAD_LIMIT_RST = 12'd2457;

  typedef struct packed {
    logic [KEY_W-1:0]  record_key;
    logic [SIZE_W-1:0] rec_size;
  } in_item_t;

  typedef struct packed {
    logic              new_key;
    logic              dropped;
    logic [SIZE_W-1:0] stored_max;
    logic [CNT_W-1:0]  distinct_keys;
    logic [SUM_W-1:0]  working_set_bytes;
  } out_item_t;

  // Access request from the control logic to the slot table.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_key_en;
    logic              wr_size_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic [SIZE_W-1:0] wr_size;
  } tbl_req_t;

  // Home slot of a (nonzero) key: low bits of key times the constant.
  // Only the low key bits reach the low product bits.
  function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [2*IDX_W-1:0] prod;
    prod = key[IDX_W-1:0] * GOLDEN[IDX_W-1:0];
    return prod[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/kmst_table.sv =====
module kmst_table import kmst_pkg::*; (
  input  logic              clk_i,
  input  tbl_req_t          req_i,
  output logic [KEY_W-1:0]  rd_key_o,
  output logic [SIZE_W-1:0] rd_size_o
);

  // Slot keys (zero means empty) and the largest size held per slot.
  logic [KEY_W-1:0]  keys_mem  [TABLE_DEPTH];
  logic [SIZE_W-1:0] sizes_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rd_key_q;
  logic [SIZE_W-1:0] rd_size_q;

  // Key memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_key_en) begin
      keys_mem[req_i.wr_addr] <= req_i.wr_key;
    end
    if (req_i.rd_en) begin
      rd_key_q <= keys_mem[req_i.rd_addr];
    end
  end

  // Size memory: written on insert and on a larger size for a held key.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_size_en) begin
      sizes_mem[req_i.wr_addr] <= req_i.wr_size;
    end
    if (req_i.rd_en) begin
      rd_size_q <= sizes_mem[req_i.rd_addr];
    end
  end

  assign rd_key_o  = rd_key_q;
  assign rd_size_o = rd_size_q;

endmodule

// ===== sv/key_max_size_tracker.sv =====
// An accepted transaction is read in S_READ and checked in S_CHECK, which registers
// its result when the first slot probed holds the key or is empty; each further probe
// is one more read of the slot memories, issued from S_CHECK, and a stalled output holds
// S_CHECK. A new transaction is taken only in S_IDLE, after the last result is registered.
// Reset: the key memory is swept to empty over all 4096 slots, one slot a cycle,
// with in_stall_o high; counters clear at once and load_limit returns to 2457.
module key_max_size_tracker import kmst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_addr_q, clr_addr_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  probe_q, probe_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic [CNT_W-1:0]  limit_q;

  tbl_req_t          req;
  logic [KEY_W-1:0]  rd_key;
  logic [SIZE_W-1:0] rd_size;
  logic [KEY_W-1:0]  in_key;
  logic [IDX_W-1:0]  pos_next;
  logic              hit, empty, last_probe, out_free;

  // Slot memories.
  kmst_table u_table (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_key_o  (rd_key),
    .rd_size_o (rd_size)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LOAD_LIMIT_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_W-1:2] == REG_LOAD_LIMIT)) begin
      limit_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_LOAD_LIMIT) ?
                  {{(DATA_W-CNT_W){1'b0}}, limit_q} : '0;

  // Probe helpers.
  assign in_key     = (in_data_i.record_key == '0) ? GOLDEN : in_data_i.record_key;
  assign pos_next   = (pos_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : pos_q + 1'b1;
  assign hit        = (rd_key == key_q);
  assign empty      = (rd_key == '0);
  assign last_probe = (probe_q == IDX_W'(TABLE_DEPTH - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: clearing sweep, then accept, read, and check/update.
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    key_d       = key_q;
    size_d      = size_q;
    pos_d       = pos_q;
    probe_d     = probe_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    req         = '0;

    unique case (state_q)
      S_CLEAR: begin
        req.wr_key_en = 1'b1;
        req.wr_addr   = clr_addr_q;
        clr_addr_d    = clr_addr_q + 1'b1;
        if (clr_addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          key_d   = in_key;
          size_d  = in_data_i.rec_size;
          pos_d   = home_slot(in_key);
          probe_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        req.rd_en   = 1'b1;
        req.rd_addr = pos_q;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (hit || empty || last_probe) begin
          if (out_free) begin
            out_d.new_key    = 1'b0;
            out_d.dropped    = 1'b0;
            out_d.stored_max = size_q;
            req.wr_addr      = pos_q;
            req.wr_key       = key_q;
            req.wr_size      = size_q;
            if (hit) begin
              // Held key: keep the larger size.
              if (size_q > rd_size) begin
                req.wr_size_en = 1'b1;
                sum_d = sum_q + {{(SUM_W-SIZE_W){1'b0}}, size_q - rd_size};
              end else begin
                out_d.stored_max = rd_size;
              end
            end else if (empty && (cnt_q < limit_q)) begin
              // New entry.
              req.wr_key_en  = 1'b1;
              req.wr_size_en = 1'b1;
              cnt_d          = cnt_q + 1'b1;
              sum_d          = sum_q + {{(SUM_W-SIZE_W){1'b0}}, size_q};
              out_d.new_key  = 1'b1;
            end else begin
              // Over the load limit, or no free slot anywhere.
              out_d.dropped = 1'b1;
            end
            out_d.distinct_keys     = cnt_d;
            out_d.working_set_bytes = sum_d;
            out_valid_d             = 1'b1;
            state_d                 = S_IDLE;
          end
        end else begin
          // Occupied by another key: read the next slot at once.
          req.rd_en   = 1'b1;
          req.rd_addr = pos_next;
          pos_d       = pos_next;
          probe_d     = probe_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Transaction payload and probe position.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    size_q  <= size_d;
    pos_q   <= pos_d;
    probe_q <= probe_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result appears only after a slot check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_CHECK))
    else $error("result raised outside of a slot check");

  // No transaction is taken while the key memory is being swept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("input open during clearing sweep");

  // A result is never both a new entry and a dropped key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.new_key && out_q.dropped))
    else $error("result flagged new and dropped");

  // The distinct-key count only ever steps up by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
    else $error("distinct-key count jumped");

endmodule
